// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define AFF2I_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked property that is also checked during reset
`define AFF2I_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/aff2i_pkg.sv =====
// ----------------------------------------------------------------------------
// aff2i_pkg
// Types and constants shared by the affine inverse pipeline.
// ----------------------------------------------------------------------------
package aff2i_pkg;

  localparam int DATA_W        = 32;
  localparam int MAG_W         = 64;
  localparam int LANES         = 6;
  localparam int FRAC_BITS_DEF = 16;

  // quotient lanes, one per result value
  localparam int LANE_C1X = 0;
  localparam int LANE_C1Y = 1;
  localparam int LANE_C2X = 2;
  localparam int LANE_C2Y = 3;
  localparam int LANE_PX  = 4;
  localparam int LANE_PY  = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] lin_xx;
    logic signed [DATA_W-1:0] lin_yx;
    logic signed [DATA_W-1:0] lin_xy;
    logic signed [DATA_W-1:0] lin_yy;
    logic signed [DATA_W-1:0] shift_x;
    logic signed [DATA_W-1:0] shift_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_c1x;
    logic signed [DATA_W-1:0] res_c1y;
    logic signed [DATA_W-1:0] res_c2x;
    logic signed [DATA_W-1:0] res_c2y;
    logic signed [DATA_W-1:0] res_px;
    logic signed [DATA_W-1:0] res_py;
    logic                     singular;
  } out_word_t;

  // one quotient in flight: partial remainder, dividend low bits that
  // shift out while quotient bits shift in, overflow and result sign
  typedef struct packed {
    logic [MAG_W-1:0]  rem;
    logic [DATA_W-1:0] lowq;
    logic              ovf;
    logic              neg;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [MAG_W-1:0]  den;
    logic              singular;
  } div_word_t;

endpackage

// ===== hw/rtl/aff2i_front.sv =====
// ----------------------------------------------------------------------------
// aff2i_front
// Products, determinant and numerators, magnitudes, divider setup (4 stages).
// ----------------------------------------------------------------------------
module aff2i_front import aff2i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  in_word_t  in_data,
  output logic      out_valid,
  output div_word_t out_data
);

  localparam int DVW  = MAG_W + FRAC_BITS;
  localparam int HI_W = DVW - DATA_W;

  function automatic logic [MAG_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? (~v + 1'b1) : v;
    return MAG_W'(m);
  endfunction

  function automatic logic [MAG_W-1:0] mag64(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic pos32(input logic signed [DATA_W-1:0] v);
    return !v[DATA_W-1] && (v != '0);
  endfunction

  function automatic logic pos64(input logic signed [MAG_W-1:0] v);
    return !v[MAG_W-1] && (v != '0);
  endfunction

  // stage 1: products
  logic signed [MAG_W-1:0]  p_ae_r, p_bc_r, p_pyc_r, p_epx_r, p_pya_r, p_bpx_r;
  logic signed [DATA_W-1:0] a1_r, b1_r, c1_r, e1_r;
  logic                     v1_r;
  // stage 2: determinant and translation numerators
  logic signed [MAG_W-1:0]  det_r, tx_r, ty_r;
  logic signed [DATA_W-1:0] a2_r, b2_r, c2_r, e2_r;
  logic                     v2_r;
  // stage 3: magnitudes and signs
  logic [MAG_W-1:0]         mag_r [LANES];
  logic [MAG_W-1:0]         mag_nxt [LANES];
  logic [LANES-1:0]         neg_r, neg_nxt;
  logic [MAG_W-1:0]         den_r, den_nxt;
  logic                     sing_r, sing_nxt;
  logic                     v3_r;
  // stage 4: divider setup
  div_word_t                s4_r, s4_nxt;
  logic                     v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ae_r  <= in_data.lin_xx  * in_data.lin_yy;
      p_bc_r  <= in_data.lin_yx  * in_data.lin_xy;
      p_pyc_r <= in_data.shift_y * in_data.lin_xy;
      p_epx_r <= in_data.lin_yy  * in_data.shift_x;
      p_pya_r <= in_data.shift_y * in_data.lin_xx;
      p_bpx_r <= in_data.lin_yx  * in_data.shift_x;
      a1_r    <= in_data.lin_xx;
      b1_r    <= in_data.lin_yx;
      c1_r    <= in_data.lin_xy;
      e1_r    <= in_data.lin_yy;

      det_r <= p_ae_r  - p_bc_r;
      tx_r  <= p_pyc_r - p_epx_r;
      ty_r  <= p_pya_r - p_bpx_r;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      e2_r  <= e1_r;

      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      den_r  <= den_nxt;
      sing_r <= sing_nxt;

      s4_r <= s4_nxt;
    end
  end

  // numerator magnitudes; the result sign is numerator sign xor det sign
  always_comb begin
    logic [LANES-1:0] nneg;
    den_nxt  = mag64(det_r);
    sing_nxt = (det_r == '0);
    mag_nxt[LANE_C1X] = mag32(e2_r);
    mag_nxt[LANE_C1Y] = mag32(c2_r);
    mag_nxt[LANE_C2X] = mag32(b2_r);
    mag_nxt[LANE_C2Y] = mag32(a2_r);
    mag_nxt[LANE_PX]  = mag64(tx_r);
    mag_nxt[LANE_PY]  = mag64(ty_r);
    nneg[LANE_C1X] = e2_r[DATA_W-1];
    nneg[LANE_C1Y] = pos32(c2_r);
    nneg[LANE_C2X] = pos32(b2_r);
    nneg[LANE_C2Y] = a2_r[DATA_W-1];
    nneg[LANE_PX]  = tx_r[MAG_W-1];
    nneg[LANE_PY]  = pos64(ty_r);
    neg_nxt = nneg ^ {LANES{det_r[MAG_W-1]}};
  end

  // dividend = magnitude << shift; the upper part seeds the remainder and
  // a quotient of 2^32 or more shows up as upper part >= divisor
  always_comb begin
    logic [DVW-1:0]   dvd;
    logic [HI_W-1:0]  hi;
    logic [MAG_W-1:0] hi_ext;
    s4_nxt.den      = den_r;
    s4_nxt.singular = sing_r;
    for (int l = 0; l < LANES; l++) begin
      dvd    = DVW'(mag_r[l]) << ((l < LANE_PX) ? 2 * FRAC_BITS : FRAC_BITS);
      hi     = dvd[DVW-1 -: HI_W];
      hi_ext = MAG_W'(hi);
      s4_nxt.lane[l].rem  = hi_ext;
      s4_nxt.lane[l].lowq = dvd[DATA_W-1:0];
      s4_nxt.lane[l].ovf  = (hi_ext >= den_r);
      s4_nxt.lane[l].neg  = neg_r[l];
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

// ===== hw/rtl/aff2i_div.sv =====
// ----------------------------------------------------------------------------
// aff2i_div
// Pipelined restoring divider, one quotient bit per stage for all lanes.
// ----------------------------------------------------------------------------
module aff2i_div import aff2i_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_data,
  output logic      out_valid,
  output div_word_t out_data
);

  div_word_t st_r [DATA_W];
  logic      v_r  [DATA_W];

  for (genvar k = 0; k < DATA_W; k++) begin : g_step
    div_word_t cur, step_nxt;
    logic      cur_v;

    if (k == 0) begin : g_first
      assign cur   = in_data;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur   = st_r[k-1];
      assign cur_v = v_r[k-1];
    end

    always_comb begin
      logic [MAG_W-1:0] trial;
      logic [MAG_W:0]   diff;
      step_nxt = cur;
      for (int l = 0; l < LANES; l++) begin
        // remainder stays below the divisor (< 2^63), so the top bit drops
        trial = {cur.lane[l].rem[MAG_W-2:0], cur.lane[l].lowq[DATA_W-1]};
        diff  = {1'b0, trial} - {1'b0, cur.den};
        step_nxt.lane[l].rem  = diff[MAG_W] ? trial : diff[MAG_W-1:0];
        step_nxt.lane[l].lowq = {cur.lane[l].lowq[DATA_W-2:0], ~diff[MAG_W]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= step_nxt;
      end
    end
  end

  assign out_valid = v_r[DATA_W-1];
  assign out_data  = st_r[DATA_W-1];

endmodule

// ===== hw/rtl/aff2i_out.sv =====
// ----------------------------------------------------------------------------
// aff2i_out
// Sign and saturation of the quotients, output register with skid entry.
// ----------------------------------------------------------------------------
module aff2i_out import aff2i_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  div_word_t in_data,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] sat_q(input lane_t ln);
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
    q = ln.lowq;
    if (ln.neg) begin
      // magnitude of exactly 2^31 still fits as the most negative value
      r = (ln.ovf || (q[DATA_W-1] && (|q[DATA_W-2:0]))) ? SAT_MIN : (~q + 1'b1);
    end else begin
      r = (ln.ovf || q[DATA_W-1]) ? SAT_MAX : q;
    end
    return r;
  endfunction

  out_word_t res;
  out_word_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;
  logic      out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic      load;

  always_comb begin
    if (in_data.singular) begin
      res          = '0;
      res.singular = 1'b1;
    end else begin
      res.res_c1x  = sat_q(in_data.lane[LANE_C1X]);
      res.res_c1y  = sat_q(in_data.lane[LANE_C1Y]);
      res.res_c2x  = sat_q(in_data.lane[LANE_C2X]);
      res.res_c2y  = sat_q(in_data.lane[LANE_C2Y]);
      res.res_px   = sat_q(in_data.lane[LANE_PX]);
      res.res_py   = sat_q(in_data.lane[LANE_PY]);
      res.singular = 1'b0;
    end
  end

  // pipeline moves only while the skid entry is free
  assign adv  = !skid_v_r;
  assign load = adv && in_valid;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    priority if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = load;
        out_d_nxt = res;
      end
    end else if (load) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end else begin
      // stalled with nothing new arriving: both entries hold
      skid_v_nxt = skid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== hw/rtl/affine_2d_inverse.sv =====
// ----------------------------------------------------------------------------
// affine_2d_inverse: inverse of a 2D affine transform, signed fixed point
// Stages: 4 front, 32 divider, 1 output register with a skid entry.
// Throughput: one word per cycle while the skid entry is free.
// Reset: synchronous rst_n clears all valid bits; no data state is kept.
// ----------------------------------------------------------------------------
module affine_2d_inverse import aff2i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      adv;
  logic      front_v, div_v;
  div_word_t front_d, div_d;

  aff2i_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_valid(front_v),
    .out_data (front_d)
  );

  aff2i_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (front_v),
    .in_data  (front_d),
    .out_valid(div_v),
    .out_data (div_d)
  );

  aff2i_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_v),
    .in_data  (div_d),
    .adv      (adv),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign in_ready = adv;

endmodule

// ===== hw/rtl/aff2i_checker.sv =====
// ----------------------------------------------------------------------------
// aff2i_checker
// Port-level checks of the affine inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aff2i_checker import aff2i_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `AFF2I_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed or dropped while stalled")
  `AFF2I_ASSERT(a_sing_zero, clk, rst_n, out_valid && out_data.singular |-> (out_data.res_c1x == '0) && (out_data.res_c1y == '0) && (out_data.res_c2x == '0) && (out_data.res_c2y == '0) && (out_data.res_px == '0) && (out_data.res_py == '0), "singular word with nonzero values")
  `AFF2I_ASSERT(a_skid_full, clk, rst_n, !in_ready |-> out_valid, "input stalled with empty output register")
  `AFF2I_ASSERT(a_stall_keep, clk, rst_n, !in_ready && !out_ready |=> !in_ready, "input released while output still stalled")
  `AFF2I_ASSERT_RST(a_reset, clk, !rst_n |=> !out_valid && in_ready, "reset did not clear the pipeline")

endmodule

bind affine_2d_inverse aff2i_checker u_aff2i_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
